// ===== rtl/core/bpme_pkg.sv =====
// shared types and constants for the box point median extent block
`timescale 1ns / 1ps
`default_nettype none
package bpme_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_BOX_LEFT   = 3'd0,
        CFG_BOX_TOP    = 3'd1,
        CFG_BOX_RIGHT  = 3'd2,
        CFG_BOX_BOTTOM = 3'd3,
        CFG_SPREAD     = 3'd4
    } cfg_idx_t;

    // rank computation steps
    typedef enum logic [1:0] {
        RANK_HI_XY = 2'd0,
        RANK_LO_XY = 2'd1,
        RANK_HI_Z  = 2'd2,
        RANK_LO_Z  = 2'd3
    } rank_sel_t;

    localparam int unsigned AXES      = 3;
    localparam int unsigned RANKS     = 3;
    localparam int unsigned K_MID     = 0;
    localparam int unsigned K_LO      = 1;
    localparam int unsigned K_HI      = 2;
    localparam logic [15:0] SIGN_BIAS = 16'h8000;
    localparam logic [17:0] HALF_FULL = 18'd65536;
    localparam logic [17:0] HALF_Z    = 18'd131072;

    // commands from controller to datapath
    typedef struct packed {
        logic      load;
        logic      capture;
        logic      rank_step;
        rank_sel_t rank_sel;
        logic      pass_clear;
        logic      read_en;
        logic      update;
        logic [3:0] bit_sel;
    } bpme_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic n_zero;
        logic addr_last;
    } bpme_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/bpme_ctrl.sv =====
// controller sequencing load, rank setup and bitwise selection passes
`timescale 1ns / 1ps
`default_nettype none
module bpme_ctrl
    import bpme_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       frame_last,
    input  bpme_stat_t      stat,
    output bpme_cmd_t       cmd,
    output logic            busy,
    output logic            done
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANK,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    state_t     state_reg;
    logic [1:0] step_reg;
    logic [3:0] bit_reg;
    logic       busy_reg;
    logic       done_reg;
    logic       accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;

    // command decode
    always_comb
    begin
        cmd            = '0;
        cmd.load       = accept;
        cmd.capture    = accept && frame_last;
        cmd.rank_step  = (state_reg == ST_RANK);
        cmd.rank_sel   = rank_sel_t'(step_reg);
        cmd.pass_clear = (state_reg == ST_RANK) || (state_reg == ST_UPDATE);
        cmd.read_en    = (state_reg == ST_SCAN);
        cmd.update     = (state_reg == ST_UPDATE);
        cmd.bit_sel    = bit_reg;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && frame_last)
                    begin
                        state_reg <= ST_RANK;
                        busy_reg  <= 1'b1;
                        step_reg  <= '0;
                        bit_reg   <= 4'd15;
                    end
                end
                ST_RANK:
                begin
                    if (stat.n_zero)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else if (step_reg == 2'd3)
                    begin
                        state_reg <= ST_SCAN;
                    end
                    step_reg <= step_reg + 2'd1;
                end
                ST_SCAN:
                begin
                    if (stat.addr_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (bit_reg == 4'd0)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg - 4'd1;
                        state_reg <= ST_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/bpme_datapath.sv =====
// point stores, rank arithmetic and per-rank radix selectors
`timescale 1ns / 1ps
`default_nettype none
module bpme_datapath
    import bpme_pkg::*;
#(
    parameter int unsigned IMAGE_WIDTH  = 352,
    parameter int unsigned IMAGE_HEIGHT = 286,
    parameter int unsigned MAX_POINTS   = 32768
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  bpme_cmd_t        cmd,
    output bpme_stat_t       stat,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic [8:0]  pixel_col,
    input  wire logic [8:0]  pixel_row,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    input  wire logic [15:0] pos_z,
    input  wire logic        point_valid,
    output logic [15:0]      center_x,
    output logic [15:0]      center_y,
    output logic [15:0]      center_z,
    output logic [15:0]      extent_x,
    output logic [15:0]      extent_y,
    output logic [15:0]      extent_z,
    output logic [15:0]      kept_count,
    output logic             set_empty
);
    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned PW = CW + 18;
    localparam logic [8:0]  RIGHT_MAX  = 9'(IMAGE_WIDTH - 1);
    localparam logic [8:0]  BOTTOM_MAX = 9'(IMAGE_HEIGHT - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_POINTS);

    logic [8:0]  left_reg, top_reg, right_reg, bottom_reg;
    logic [15:0] frac_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= 9'd0;
            top_reg    <= 9'd0;
            right_reg  <= 9'd351;
            bottom_reg <= 9'd285;
            frac_reg   <= 16'd32768;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BOX_LEFT:   left_reg   <= cfg_data[8:0];
                CFG_BOX_TOP:    top_reg    <= cfg_data[8:0];
                CFG_BOX_RIGHT:  right_reg  <= cfg_data[8:0];
                CFG_BOX_BOTTOM: bottom_reg <= cfg_data[8:0];
                CFG_SPREAD:     frac_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // box test
    logic [8:0] right_eff, bottom_eff;
    logic       keep;
    assign right_eff  = (right_reg < RIGHT_MAX) ? right_reg : RIGHT_MAX;
    assign bottom_eff = (bottom_reg < BOTTOM_MAX) ? bottom_reg : BOTTOM_MAX;
    assign keep = point_valid && (pixel_col >= left_reg) && (pixel_col < right_eff)
               && (pixel_row >= top_reg) && (pixel_row < bottom_eff)
               && (pixel_col[0] == left_reg[0]) && (pixel_row[0] == top_reg[0]);

    logic [CW-1:0] count_reg, count_next, n_reg;
    logic          store_en;
    assign store_en   = cmd.load && keep && (count_reg < COUNT_MAX);
    assign count_next = store_en ? count_reg + CW'(1) : count_reg;

    // point counter and frame size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            n_reg     <= '0;
        end
        else if (cmd.capture)
        begin
            count_reg <= '0;
            n_reg     <= count_next;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    logic [15:0] x_mem [MAX_POINTS];
    logic [15:0] y_mem [MAX_POINTS];
    logic [15:0] z_mem [MAX_POINTS];
    logic [15:0] rd_data [AXES];
    logic [AW-1:0] addr_reg;
    logic          rd_valid_reg;

    // biased coordinate stores, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            x_mem[count_reg[AW-1:0]] <= pos_x ^ SIGN_BIAS;
            y_mem[count_reg[AW-1:0]] <= pos_y ^ SIGN_BIAS;
            z_mem[count_reg[AW-1:0]] <= pos_z ^ SIGN_BIAS;
        end
        rd_data[0] <= x_mem[addr_reg];
        rd_data[1] <= y_mem[addr_reg];
        rd_data[2] <= z_mem[addr_reg];
    end

    // scan address and read valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.read_en;
            if (cmd.pass_clear)
                addr_reg <= '0;
            else if (cmd.read_en)
                addr_reg <= addr_reg + AW'(1);
        end
    end

    assign stat.addr_last = (CW'(addr_reg) == CW'(n_reg - CW'(1)));
    assign stat.n_zero    = (n_reg == '0);

    // rank arithmetic, one product per step
    logic [17:0]   mult;
    logic [PW-1:0] prod;
    logic [CW-1:0] rank_val, n_minus1;
    always_comb
    begin
        unique case (cmd.rank_sel)
            RANK_HI_XY: mult = HALF_FULL + 18'(frac_reg);
            RANK_LO_XY: mult = HALF_FULL - 18'(frac_reg);
            RANK_HI_Z:  mult = HALF_Z + 18'(frac_reg);
            RANK_LO_Z:  mult = HALF_Z - 18'(frac_reg);
            default:    mult = HALF_FULL;
        endcase
    end
    assign prod     = PW'(n_reg) * PW'(mult);
    assign n_minus1 = n_reg - CW'(1);
    always_comb
    begin
        if (cmd.rank_sel == RANK_HI_XY || cmd.rank_sel == RANK_LO_XY)
            rank_val = prod[17 +: CW];
        else
            rank_val = prod[18 +: CW];
        if ((cmd.rank_sel == RANK_HI_XY || cmd.rank_sel == RANK_HI_Z)
            && rank_val > n_minus1)
            rank_val = n_minus1;
    end

    // radix selectors: prefix, remaining rank and match count per rank
    logic [15:0]   prefix_reg [AXES][RANKS];
    logic [CW-1:0] rem_reg    [AXES][RANKS];
    logic [CW-1:0] cnt_reg    [AXES][RANKS];
    logic [15:0]   hmask;
    assign hmask = 16'(17'h1FFFF << ({1'b0, cmd.bit_sel} + 5'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
                for (int k = 0; k < RANKS; k++)
                begin
                    prefix_reg[a][k] <= '0;
                    rem_reg[a][k]    <= '0;
                    cnt_reg[a][k]    <= '0;
                end
        end
        else
        begin
            for (int a = 0; a < AXES; a++)
                for (int k = 0; k < RANKS; k++)
                begin
                    if (cmd.capture)
                    begin
                        prefix_reg[a][k] <= '0;
                        if (k == K_MID)
                            rem_reg[a][k] <= count_next >> 1;
                    end
                    if (cmd.rank_step)
                    begin
                        if ((a < 2 && k == K_HI && cmd.rank_sel == RANK_HI_XY)
                            || (a < 2 && k == K_LO && cmd.rank_sel == RANK_LO_XY)
                            || (a == 2 && k == K_HI && cmd.rank_sel == RANK_HI_Z)
                            || (a == 2 && k == K_LO && cmd.rank_sel == RANK_LO_Z))
                            rem_reg[a][k] <= rank_val;
                    end
                    if (cmd.update)
                    begin
                        if (rem_reg[a][k] >= cnt_reg[a][k])
                        begin
                            prefix_reg[a][k][cmd.bit_sel] <= 1'b1;
                            rem_reg[a][k] <= rem_reg[a][k] - cnt_reg[a][k];
                        end
                    end
                    if (cmd.pass_clear)
                        cnt_reg[a][k] <= '0;
                    else if (rd_valid_reg
                             && (((rd_data[a] ^ prefix_reg[a][k]) & hmask) == 16'd0)
                             && !rd_data[a][cmd.bit_sel])
                        cnt_reg[a][k] <= cnt_reg[a][k] + CW'(1);
                end
        end
    end

    // result fields
    always_comb
    begin
        if (n_reg == '0)
        begin
            center_x  = '0;
            center_y  = '0;
            center_z  = '0;
            extent_x  = '0;
            extent_y  = '0;
            extent_z  = '0;
            set_empty = 1'b1;
        end
        else
        begin
            center_x  = prefix_reg[0][K_MID] ^ SIGN_BIAS;
            center_y  = prefix_reg[1][K_MID] ^ SIGN_BIAS;
            center_z  = prefix_reg[2][K_MID] ^ SIGN_BIAS;
            extent_x  = prefix_reg[0][K_HI] - prefix_reg[0][K_LO];
            extent_y  = prefix_reg[1][K_HI] - prefix_reg[1][K_LO];
            extent_z  = prefix_reg[2][K_HI] - prefix_reg[2][K_LO];
            set_empty = 1'b0;
        end
        kept_count = 16'(n_reg);
    end
endmodule
`default_nettype wire

// ===== rtl/core/box_point_median_extent_top.sv =====
// top level of the box point median extent block
//
// channel   direction  handshake              fields
// config    in         cfg_write              cfg_index, cfg_data
// point     in         start & !busy          pixel_col .. frame_last
// result    out        done (one cycle)       center_*, extent_*, kept_count, set_empty
//
// points are taken one per cycle while loading
// after the last point: rank setup steps, then 16 passes over the stores
// (one read port per axis), each pass a scan, a drain and an update state
// an empty frame reports straight from rank setup; reset clears control, not the stores
// the receiver cannot stall; done is a single-cycle strobe
`timescale 1ns / 1ps
`default_nettype none
module box_point_median_extent_top
    import bpme_pkg::*;
#(
    parameter int unsigned IMAGE_WIDTH  = 352,
    parameter int unsigned IMAGE_HEIGHT = 286,
    parameter int unsigned MAX_POINTS   = 32768
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [8:0]  pixel_col,
    input  wire logic [8:0]  pixel_row,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    input  wire logic [15:0] pos_z,
    input  wire logic        point_valid,
    input  wire logic        frame_last,
    output logic             done,
    output logic [15:0]      center_x,
    output logic [15:0]      center_y,
    output logic [15:0]      center_z,
    output logic [15:0]      extent_x,
    output logic [15:0]      extent_y,
    output logic [15:0]      extent_z,
    output logic [15:0]      kept_count,
    output logic             set_empty
);
    bpme_cmd_t  cmd;
    bpme_stat_t stat;

    // sequencing
    bpme_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .frame_last (frame_last),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    // storage and selection
    bpme_datapath #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .MAX_POINTS   (MAX_POINTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .point_valid (point_valid),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .extent_x    (extent_x),
        .extent_y    (extent_y),
        .extent_z    (extent_z),
        .kept_count  (kept_count),
        .set_empty   (set_empty)
    );
endmodule
`default_nettype wire

// ===== test/box_point_median_extent_top_tb.sv =====
// self-checking testbench for the box point median extent block
`timescale 1ns / 1ps
module box_point_median_extent_top_tb;
    import bpme_pkg::*;

    localparam int unsigned IMG_W   = 352;
    localparam int unsigned IMG_H   = 286;
    localparam int unsigned MAX_PTS = 32768;

    // one frame summary
    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cz;
        logic [15:0] ex;
        logic [15:0] ey;
        logic [15:0] ez;
        logic [15:0] cnt;
        logic        empty;
    } summary_t;

    // frame predictor and pending summaries
    class frame_scoreboard;
        logic [8:0]  left, top, right, bottom;
        logic [15:0] frac;
        logic [15:0] xs[$];
        logic [15:0] ys[$];
        logic [15:0] zs[$];
        summary_t    pending[$];
        int          errors;

        function new();
            left = 0;
            top = 0;
            right = 351;
            bottom = 285;
            frac = 16'd32768;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] val);
            case (idx)
                CFG_BOX_LEFT:   left = val[8:0];
                CFG_BOX_TOP:    top = val[8:0];
                CFG_BOX_RIGHT:  right = val[8:0];
                CFG_BOX_BOTTOM: bottom = val[8:0];
                CFG_SPREAD:     frac = val;
                default: ;
            endcase
        endfunction

        // spread between two percentile ranks of a sorted biased axis
        function logic [15:0] axis_spread(logic [15:0] s[$], int shift);
            longint unsigned n, halfv, hi, lo;
            logic [15:0] d;
            n = s.size();
            halfv = 64'd1 << (shift - 1);
            hi = (n * (halfv + frac)) >> shift;
            lo = (n * (halfv - frac)) >> shift;
            if (hi > n - 1) hi = n - 1;
            d = s[hi] - s[lo];
            return d;
        endfunction

        function void note_point(logic [8:0] col, logic [8:0] row, logic [15:0] x,
                                 logic [15:0] y, logic [15:0] z, logic vld, logic lst);
            int unsigned r, b, n;
            summary_t e;
            r = (right < IMG_W - 1) ? right : IMG_W - 1;
            b = (bottom < IMG_H - 1) ? bottom : IMG_H - 1;
            if (vld && col >= left && col < r && row >= top && row < b
                && ((col - left) & 1) == 0 && ((row - top) & 1) == 0
                && xs.size() < MAX_PTS) begin
                xs.insert(xs.size(), x ^ SIGN_BIAS);
                ys.insert(ys.size(), y ^ SIGN_BIAS);
                zs.insert(zs.size(), z ^ SIGN_BIAS);
            end
            if (!lst) return;
            e = '0;
            n = xs.size();
            if (n == 0) e.empty = 1'b1;
            else begin
                xs.sort();
                ys.sort();
                zs.sort();
                e.cx = xs[n / 2] ^ SIGN_BIAS;
                e.cy = ys[n / 2] ^ SIGN_BIAS;
                e.cz = zs[n / 2] ^ SIGN_BIAS;
                e.ex = axis_spread(xs, 17);
                e.ey = axis_spread(ys, 17);
                e.ez = axis_spread(zs, 18);
                e.cnt = n[15:0];
            end
            pending.insert(pending.size(), e);
            xs.delete();
            ys.delete();
            zs.delete();
        endfunction

        function void check_summary(summary_t got);
            summary_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.cx != got.cx) report("center_x", e.cx, got.cx);
            if (e.cy != got.cy) report("center_y", e.cy, got.cy);
            if (e.cz != got.cz) report("center_z", e.cz, got.cz);
            if (e.ex != got.ex) report("extent_x", e.ex, got.ex);
            if (e.ey != got.ey) report("extent_y", e.ey, got.ey);
            if (e.ez != got.ez) report("extent_z", e.ez, got.ez);
            if (e.cnt != got.cnt) report("kept_count", e.cnt, got.cnt);
            if (e.empty != got.empty) report("set_empty", e.empty, got.empty);
        endfunction

        function void report(string f, logic [15:0] e, logic [15:0] a);
            $display("%0t: %s mismatch expected %h actual %h", $time, f, e, a);
            errors++;
        endfunction
    endclass

    logic        clk, rst_n, cfg_write, start, busy, done;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic [8:0]  pixel_col, pixel_row;
    logic [15:0] pos_x, pos_y, pos_z;
    logic        point_valid, frame_last;
    logic [15:0] center_x, center_y, center_z, extent_x, extent_y, extent_z, kept_count;
    logic        set_empty;

    frame_scoreboard sb;
    int idle_pct;
    int sent;

    box_point_median_extent_top i_dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_summary({center_x, center_y, center_z, extent_x, extent_y,
                              extent_z, kept_count, set_empty});
    end

    // watchdog
    initial
    begin
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // wait for every summary, then for the block to settle
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // send one point transaction; start stays high for a following transaction
    task automatic send_point(logic [8:0] col, logic [8:0] row, logic [15:0] x,
                              logic [15:0] y, logic [15:0] z, logic vld, logic lst);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        point_valid <= vld;
        frame_last <= lst;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_point(col, row, x, y, z, vld, lst);
        sent++;
    endtask

    // frame of mostly kept points with random content
    task automatic random_frame(int len);
        int unsigned c, r;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) < 8)
            begin
                c = sb.left + 2 * $urandom_range(3);
                r = sb.top + 2 * $urandom_range(3);
            end
            else
            begin
                c = $urandom_range(511);
                r = $urandom_range(511);
            end
            send_point(c[8:0], r[8:0], 16'($urandom), 16'($urandom), 16'($urandom),
                       $urandom_range(15) != 0, i == len - 1);
        end
    endtask

    initial
    begin
        cfg_write = 0; cfg_index = 0; cfg_data = 0; start = 0;
        pixel_col = 0; pixel_row = 0; pos_x = 0; pos_y = 0; pos_z = 0;
        point_valid = 0; frame_last = 0;
        sb = new();
        idle_pct = 0;
        sent = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty frame, extremes, invalid, degenerate box
        send_point(0, 0, 16'h7fff, 16'h8000, 16'h0000, 1'b1, 1'b0);
        send_point(2, 0, 16'h8000, 16'h7fff, 16'hffff, 1'b1, 1'b0);
        send_point(1, 0, 16'h1234, 16'h1234, 16'h1234, 1'b1, 1'b0);
        send_point(4, 2, 16'h5555, 16'haaaa, 16'h0001, 1'b0, 1'b0);
        send_point(350, 284, 16'h0100, 16'h0200, 16'h0300, 1'b1, 1'b0);
        send_point(511, 511, 16'h0100, 16'h0200, 16'h0300, 1'b1, 1'b1);
        send_point(0, 0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1);
        drain();
        write_reg(CFG_SPREAD, 16'hffff);
        send_point(0, 0, 16'h7fff, 16'h0, 16'h8000, 1'b1, 1'b0);
        send_point(2, 2, 16'h8000, 16'h1, 16'h7fff, 1'b1, 1'b0);
        send_point(4, 4, 16'h0000, 16'hffff, 16'h0, 1'b1, 1'b1);
        drain();
        write_reg(CFG_SPREAD, 16'h0000);
        write_reg(CFG_BOX_LEFT, 16'd511);
        write_reg(CFG_BOX_TOP, 16'd511);
        send_point(511, 511, 16'h1, 16'h2, 16'h3, 1'b1, 1'b1);
        drain();
        write_reg(CFG_BOX_LEFT, 16'd10);
        write_reg(CFG_BOX_TOP, 16'd5);
        write_reg(CFG_BOX_RIGHT, 16'd10);
        write_reg(CFG_BOX_BOTTOM, 16'd511);
        send_point(10, 5, 16'h1, 16'h2, 16'h3, 1'b1, 1'b1);
        drain();
        write_reg(CFG_BOX_RIGHT, 16'd511);
        write_reg(CFG_BOX_BOTTOM, 16'd0);
        send_point(10, 5, 16'h1, 16'h2, 16'h3, 1'b1, 1'b1);
        drain();

        // random phases through several box settings and idle patterns
        for (int ph = 0; ph < 12; ph++)
        begin
            idle_pct = (ph < 4) ? 19 : (ph < 8) ? 69 : 0;
            drain();
            write_reg(CFG_BOX_LEFT,
                      $urandom_range(3) == 0 ? 16'd0 : 16'($urandom_range(340)));
            write_reg(CFG_BOX_TOP,
                      $urandom_range(3) == 0 ? 16'd0 : 16'($urandom_range(280)));
            write_reg(CFG_BOX_RIGHT,
                      $urandom_range(3) == 0 ? 16'd511 : 16'($urandom_range(511)));
            write_reg(CFG_BOX_BOTTOM,
                      $urandom_range(3) == 0 ? 16'd511 : 16'($urandom_range(511)));
            write_reg(CFG_SPREAD, $urandom_range(2) == 0 ? 16'hffff : 16'($urandom));
            if (sb.right <= sb.left) write_reg(CFG_BOX_RIGHT, 16'd511);
            if (sb.bottom <= sb.top) write_reg(CFG_BOX_BOTTOM, 16'd511);
            while (sent < 40 + (ph + 1) * 105)
            begin
                random_frame($urandom_range(1, 40));
                // occasionally hold off until every summary is back
                if ($urandom_range(7) == 0) drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bpme_pkg.sv
rtl/core/bpme_ctrl.sv
rtl/core/bpme_datapath.sv
rtl/core/box_point_median_extent_top.sv
test/box_point_median_extent_top_tb.sv
